// ===== rtl/core/cfc_pkg.sv =====
// Shared types, widths and helpers for the causal FIR convolution core.
// No dependencies; every module of the core imports this package.
package cfc_pkg;

	localparam int SAMPLE_W  = 16;   // input sample width
	localparam int COEF_W    = 16;   // Q1.15 coefficient width
	localparam int PROD_W    = 32;   // full product of sample and coefficient
	localparam int OUT_W     = 34;   // filtered result width
	localparam int NUM_REGS  = 8;    // coefficient registers on the write port
	localparam int REG_IDX_W = 3;    // width of the register index
	localparam int TAPS_DEF  = 8;    // default kernel length

	// Per-cell control: shift the history chain and clear it for a new block
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

	// Number of adder levels in the sum tree (at least one)
	function automatic int tree_levels(input int taps);
		return (taps > 1) ? $clog2(taps) : 1;
	endfunction

endpackage

// ===== rtl/core/cfc_cell.sv =====
// One tap cell of the FIR chain: a history register, its tap value and product.
// Depends on cfc_pkg.
module cfc_cell import cfc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cell_ctrl_t                 ctrl,
	input  logic signed [SAMPLE_W-1:0] tap_in,
	input  logic signed [COEF_W-1:0]   coef,
	output logic signed [SAMPLE_W-1:0] tap_out,
	output logic signed [PROD_W-1:0]   prod_s1
);

	logic signed [SAMPLE_W-1:0] hist_q;
	logic signed [PROD_W-1:0]   mult;

	// Hold one history sample; take the neighbor's tap on each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (ctrl.shift) begin
			hist_q <= tap_in;
		end
	end

	// Drop the history at a block start
	assign tap_out = ctrl.clear ? '0 : hist_q;

	// Multiply this tap by its coefficient and register the product
	assign mult = tap_in * coef;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			prod_s1 <= mult;
		end
	end

endmodule

// ===== rtl/core/cfc_sum_tree.sv =====
// Registered binary adder tree over the tap products, one level per stage.
// Depends on cfc_pkg.
module cfc_sum_tree import cfc_pkg::*; #(
	parameter int TAPS   = TAPS_DEF,
	parameter int LEVELS = tree_levels(TAPS),
	parameter int SUM_W  = PROD_W + LEVELS
) (
	input  logic                     clk,
	input  logic signed [PROD_W-1:0] leaf_prod [TAPS],
	input  logic [LEVELS-1:0]        level_en,
	output logic signed [SUM_W-1:0]  root
);

	localparam int N2 = 1 << LEVELS;

	logic signed [SUM_W-1:0] leaf   [N2];
	logic signed [SUM_W-1:0] node_q [N2-1];

	// Sign-extend the products; pad missing leaves with zero
	for (genvar k = 0; k < N2; k++) begin : g_leaf
		if (k < TAPS) begin : g_used
			assign leaf[k] = SUM_W'(leaf_prod[k]);
		end else begin : g_pad
			assign leaf[k] = '0;
		end
	end

	// Heap-ordered nodes: node i adds children 2i+1 and 2i+2
	for (genvar i = 0; i < N2 - 1; i++) begin : g_node
		localparam int D  = $clog2(i + 2) - 1;
		localparam int C0 = 2 * i + 1;
		localparam int C1 = 2 * i + 2;
		logic signed [SUM_W-1:0] a;
		logic signed [SUM_W-1:0] b;

		if (C0 >= N2 - 1) begin : g_from_leaf
			assign a = leaf[C0 - (N2 - 1)];
			assign b = leaf[C1 - (N2 - 1)];
		end else begin : g_from_node
			assign a = node_q[C0];
			assign b = node_q[C1];
		end

		// Advance this level with its pipeline stage
		always_ff @(posedge clk) begin
			if (level_en[LEVELS - D - 1]) begin
				node_q[i] <= a + b;
			end
		end
	end

	assign root = node_q[0];

endmodule

// ===== rtl/core/causal_fir_convolution_core.sv =====
// Top level of the causal direct-form FIR core: coefficient registers, tap cell
// chain, sum tree, handshake pipeline and output saturation. Uses cfc_pkg,
// cfc_cell and cfc_sum_tree.
//
//   channel    signals                                   direction
//   sample     sample_valid, sample_stall, sample,       in
//              block_start, block_end
//   result     filtered_valid, filtered_stall,           out
//              filtered, end_of_block
//   config     wr_en, wr_index, wr_data                  in
//
// One sample per cycle is taken while the input is not stalled. The product stage
// loads at the accepting edge, then one stage per adder level and the output
// register follow, and the result is presented from the output register.
// Each stage advances when empty or when the stage after it advances, so
// bubbles close up and input is stalled only when every stage is full and the
// result is stalled.
// Reset clears the history, the coefficients and all valid flags.
module causal_fir_convolution_core import cfc_pkg::*; #(
	parameter int TAPS = TAPS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	output logic                        sample_stall,
	input  logic signed [SAMPLE_W-1:0]  sample,
	input  logic                        block_start,
	input  logic                        block_end,
	output logic                        filtered_valid,
	input  logic                        filtered_stall,
	output logic signed [OUT_W-1:0]     filtered,
	output logic                        end_of_block,
	input  logic                        wr_en,
	input  logic [REG_IDX_W-1:0]        wr_index,
	input  logic signed [COEF_W-1:0]    wr_data
);

	localparam int LEVELS = tree_levels(TAPS);
	localparam int SUM_W  = PROD_W + LEVELS;
	localparam int EXT_W  = (SUM_W > OUT_W) ? SUM_W : OUT_W;
	localparam int NST    = LEVELS + 2;
	localparam int NREG   = (TAPS < NUM_REGS) ? TAPS : NUM_REGS;

	logic signed [COEF_W-1:0]   coef_q [NREG];
	logic signed [SAMPLE_W-1:0] taps   [TAPS];
	logic signed [PROD_W-1:0]   prods  [TAPS];
	logic signed [SUM_W-1:0]    root;
	logic signed [EXT_W-1:0]    ext;
	logic [EXT_W-OUT_W:0]       ext_top;
	logic signed [OUT_W-1:0]    sat;
	logic [NST-1:0]             adv;
	logic [NST-1:0]             vld_q;
	logic [NST-1:0]             eob_q;
	logic                       accept;
	cell_ctrl_t                 cell_ctrl;

	// Write coefficients; indices past the kernel are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NREG; r++) begin
				coef_q[r] <= '0;
			end
		end else if (wr_en) begin
			for (int r = 0; r < NREG; r++) begin
				if (wr_index == REG_IDX_W'(r)) begin
					coef_q[r] <= wr_data;
				end
			end
		end
	end

	// Stage advance: a stage moves when it is empty or its successor moves
	always_comb begin
		adv[NST-1] = !vld_q[NST-1] || !filtered_stall;
		for (int k = NST - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign sample_stall    = !adv[0];
	assign accept          = sample_valid && adv[0];
	assign cell_ctrl.shift = accept;
	assign cell_ctrl.clear = block_start;

	// Tap cell chain: the current sample enters cell 0, history moves right
	assign taps[0] = sample;

	for (genvar j = 0; j < TAPS; j++) begin : g_cell
		logic signed [COEF_W-1:0] cell_coef;

		if (j < NREG) begin : g_coef
			assign cell_coef = coef_q[j];
		end else begin : g_zero
			assign cell_coef = '0;
		end

		if (j < TAPS - 1) begin : g_mid
			cfc_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (cell_ctrl),
				.tap_in  (taps[j]),
				.coef    (cell_coef),
				.tap_out (taps[j+1]),
				.prod_s1 (prods[j])
			);
		end else begin : g_last
			cfc_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (cell_ctrl),
				.tap_in  (taps[j]),
				.coef    (cell_coef),
				.tap_out (),
				.prod_s1 (prods[j])
			);
		end
	end

	// Sum the products through the registered tree
	cfc_sum_tree #(
		.TAPS   (TAPS),
		.LEVELS (LEVELS),
		.SUM_W  (SUM_W)
	) u_sum_tree (
		.clk       (clk),
		.leaf_prod (prods),
		.level_en  (adv[LEVELS:1]),
		.root      (root)
	);

	// Valid flags follow the transaction down the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= accept;
			end
			for (int k = 1; k < NST; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Carry the block end flag alongside
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			eob_q[0] <= block_end;
		end
		for (int k = 1; k < NST; k++) begin
			if (adv[k]) begin
				eob_q[k] <= eob_q[k-1];
			end
		end
	end

	// Clamp the sum to the output range
	assign ext     = EXT_W'(root);
	assign ext_top = ext[EXT_W-1:OUT_W-1];

	always_comb begin
		if ((&ext_top) || !(|ext_top)) begin
			sat = ext[OUT_W-1:0];
		end else if (ext[EXT_W-1]) begin
			sat = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(OUT_W-1){1'b1}}};
		end
	end

	// Output register
	logic signed [OUT_W-1:0] filtered_q;

	always_ff @(posedge clk) begin
		if (adv[NST-1]) begin
			filtered_q <= sat;
		end
	end

	assign filtered       = filtered_q;
	assign filtered_valid = vld_q[NST-1];
	assign end_of_block   = eob_q[NST-1];

endmodule
